// ===== hdl/dat_pkg.sv =====
`timescale 1ns / 1ps

package dat_pkg;

    localparam int SLOTS = 32;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] MODE_DAEMON   = 3'd0;
    localparam logic [2:0] MODE_FUSE     = 3'd1;
    localparam logic [2:0] MODE_REMOVE   = 3'd2;
    localparam logic [2:0] MODE_LENGTHEN = 3'd3;
    localparam logic [2:0] MODE_RUN      = 3'd4;
    localparam logic [2:0] MODE_TICK     = 3'd5;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    localparam logic [1:0]  KIND_EMPTY  = 2'd0;
    localparam logic [15:0] DAEMON_TIME = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         action_id;
        logic signed [15:0] argument;
        logic [1:0]         phase_kind;
        logic signed [15:0] amount;
    } t_in_item;

    typedef struct packed {
        logic               fired;
        logic [7:0]         fire_action_id;
        logic signed [15:0] fire_argument;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         action;
        logic signed [15:0] argument;
        logic signed [15:0] ticks;
    } t_slot;

endpackage

// ===== hdl/dat_in_if.sv =====
`timescale 1ns / 1ps

interface dat_in_if;
    import dat_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== hdl/dat_out_if.sv =====
`timescale 1ns / 1ps

interface dat_out_if;
    import dat_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== hdl/delayed_action_timer_table_core.sv =====
`timescale 1ns / 1ps

// channel  direction  item                                             handshake
// i_in     in         mode, action_id, argument, phase_kind, amount    valid/ready
// o_out    out        fired, fire_action_id, fire_argument, status,    valid/ready
//                     last
//
// a single scan sequencer over the slot memory examines one slot per cycle while
// o_out does not stall; start stops at the first empty slot, remove and lengthen
// at the first hit, while run and tick visit every slot and then flush
// not ready while an item is in progress; a finished item waits in the output register
// synchronous reset empties every slot at once through the per-slot kind registers

module delayed_action_timer_table_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dat_in_if.sink   i_in,
    dat_out_if.source o_out
);
    import dat_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_in_item   r_item;
    logic [1:0] r_kind [SLOTS];
    t_slot      r_mem [SLOTS];
    t_slot      r_q;
    logic       r_pend_v, n_pend_v;
    t_out_item  r_pend, n_pend;
    logic       r_ov;
    t_out_item  r_out;

    logic       w_en;
    t_slot      w_data;
    logic       k_we;
    logic [1:0] k_data;
    logic       emit;
    t_out_item  e_item;
    t_out_item  fire_item;

    logic [1:0] kind_cur;
    logic       occupied, match_phase, can_emit, last_slot;
    logic       is_start, is_find, is_scan;
    logic       hit, fuse_live, fire, proceed;
    logic signed [16:0] l_sum;
    logic signed [15:0] l_sat;

    assign kind_cur    = r_kind[r_idx];
    assign occupied    = (kind_cur != KIND_EMPTY);
    assign match_phase = (r_item.phase_kind != KIND_EMPTY) && (kind_cur == r_item.phase_kind);
    assign can_emit    = !r_ov || o_out.ready;
    assign last_slot   = (r_idx == IDX_W'(SLOTS - 1));

    assign is_start = (r_item.mode == MODE_DAEMON) || (r_item.mode == MODE_FUSE);
    assign is_find  = (r_item.mode == MODE_REMOVE) || (r_item.mode == MODE_LENGTHEN);
    assign is_scan  = (r_item.mode == MODE_RUN) || (r_item.mode == MODE_TICK);

    assign hit       = occupied && (r_q.action == r_item.action_id);
    assign fuse_live = !r_q.ticks[15] && (r_q.ticks != 16'sd0);
    assign fire      = match_phase && ((r_item.mode == MODE_RUN) ?
                       (r_q.ticks == DAEMON_TIME) :
                       ((r_item.mode == MODE_TICK) && fuse_live && (r_q.ticks == 16'sd1)));
    assign proceed   = !(fire && r_pend_v && !can_emit);

    // saturating add for lengthen
    assign l_sum = {r_q.ticks[15], r_q.ticks} + {r_item.amount[15], r_item.amount};
    assign l_sat = (l_sum[16] != l_sum[15]) ? (l_sum[16] ? 16'sh8000 : 16'sh7FFF)
                                            : l_sum[15:0];

    always_comb begin
        fire_item                = '0;
        fire_item.fired          = 1'b1;
        fire_item.fire_action_id = r_q.action;
        fire_item.fire_argument  = r_q.argument;
        fire_item.status         = ST_DONE;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        w_en     = 1'b0;
        w_data   = r_q;
        k_we     = 1'b0;
        k_data   = kind_cur;
        emit     = 1'b0;
        e_item   = '0;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (is_start) begin
                    if (!occupied) begin
                        if (can_emit) begin
                            emit          = 1'b1;
                            e_item.status = ST_DONE;
                            e_item.last   = 1'b1;
                            w_en          = 1'b1;
                            w_data.action = r_item.action_id;
                            w_data.argument = r_item.argument;
                            w_data.ticks  = (r_item.mode == MODE_DAEMON) ? DAEMON_TIME
                                                                         : r_item.amount;
                            k_we          = 1'b1;
                            k_data        = r_item.phase_kind;
                            n_state       = S_IDLE;
                            n_idx         = '0;
                        end
                    end else if (last_slot) begin
                        if (can_emit) begin
                            emit          = 1'b1;
                            e_item.status = ST_FULL;
                            e_item.last   = 1'b1;
                            n_state       = S_IDLE;
                            n_idx         = '0;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (is_find) begin
                    if (hit) begin
                        if (can_emit) begin
                            emit          = 1'b1;
                            e_item.status = ST_DONE;
                            e_item.last   = 1'b1;
                            if (r_item.mode == MODE_REMOVE) begin
                                k_we   = 1'b1;
                                k_data = KIND_EMPTY;
                            end else begin
                                w_en         = 1'b1;
                                w_data.ticks = l_sat;
                            end
                            n_state = S_IDLE;
                            n_idx   = '0;
                        end
                    end else if (last_slot) begin
                        if (can_emit) begin
                            emit          = 1'b1;
                            e_item.status = ST_NOT_FOUND;
                            e_item.last   = 1'b1;
                            n_state       = S_IDLE;
                            n_idx         = '0;
                        end
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (is_scan) begin
                    if (proceed) begin
                        if ((r_item.mode == MODE_TICK) && match_phase && fuse_live) begin
                            w_en         = 1'b1;
                            w_data.ticks = r_q.ticks - 16'sd1;
                            if (r_q.ticks == 16'sd1) begin
                                k_we   = 1'b1;
                                k_data = KIND_EMPTY;
                            end
                        end
                        if (fire) begin
                            if (r_pend_v) begin
                                emit   = 1'b1;
                                e_item = r_pend;
                            end
                            n_pend_v = 1'b1;
                            n_pend   = fire_item;
                        end
                        if (last_slot) begin
                            n_state = S_FLUSH;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end
                end else begin
                    if (can_emit) begin
                        emit          = 1'b1;
                        e_item.status = ST_DONE;
                        e_item.last   = 1'b1;
                        n_state       = S_IDLE;
                        n_idx         = '0;
                    end
                end
            end
            S_FLUSH: begin
                n_idx = '0;
                if (can_emit) begin
                    emit = 1'b1;
                    if (r_pend_v) begin
                        e_item = r_pend;
                    end else begin
                        e_item.status = ST_NONE;
                    end
                    e_item.last = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_kind[k] <= KIND_EMPTY;
            end
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pend_v <= n_pend_v;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (k_we) begin
                r_kind[r_idx] <= k_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.item;
        end
        if (emit) begin
            r_out <= e_item;
        end
        r_pend <= n_pend;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[r_idx] <= w_data;
        end
        r_q <= r_mem[n_idx];
    end

endmodule
